### sv/mrfow_pkg.sv
`timescale 1ns / 1ps

package mrfow_pkg;

    // Ring capacity; at most DEPTH-1 words are held
    localparam int DEPTH  = 4096;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int MSG_W  = 64;
    localparam int KIND_W = 2;
    localparam int LEN_W  = 12;
    localparam int BASE_W = 16;
    localparam int THR_W  = 17;

    localparam logic [LEN_W-1:0]  LEN_MAX    = '1;
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(1024);

    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RDOVL = 2'd2;

    typedef struct packed {
        logic accept;   // take the input word and update queue state
        logic step;     // one threshold doubling
        logic load;     // move the pending result into the output register
    } t_cmd;

    typedef struct packed {
        logic need_double;
        logic out_free;
    } t_sts;

    // Clamp a length to the 12-bit result field
    function automatic logic [LEN_W-1:0] sat_len(input logic [ADDR_W-1:0] v);
        logic [ADDR_W+LEN_W-1:0] wide;
        wide = {{LEN_W{1'b0}}, v};
        if (wide > {{ADDR_W{1'b0}}, LEN_MAX}) begin
            return LEN_MAX;
        end
        return wide[LEN_W-1:0];
    endfunction

endpackage

### sv/mrfow_ram.sv
`timescale 1ns / 1ps

module mrfow_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mrfow_ctrl.sv
`timescale 1ns / 1ps

module mrfow_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mrfow_pkg::t_sts i_sts,
    output mrfow_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RUN;
                end
            end
            S_RUN: begin
                // double until the length no longer exceeds the threshold
                if (i_sts.need_double) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_accept_then_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_RUN))
        else $error("accepted word did not start processing");

    a_load_after_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!i_sts.need_double && i_sts.out_free))
        else $error("result loaded before threshold settled or into busy output");

endmodule

### sv/mrfow_dp.sv
`timescale 1ns / 1ps

module mrfow_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mrfow_pkg::t_cmd                     i_cmd,
    output mrfow_pkg::t_sts                     o_sts,
    input  logic [mrfow_pkg::KIND_W-1:0]        i_kind,
    input  logic [mrfow_pkg::MSG_W-1:0]         i_message_in,
    input  logic [mrfow_pkg::BASE_W-1:0]        i_base,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [mrfow_pkg::MSG_W-1:0]         o_message_out,
    output logic                                o_got_message,
    output logic                                o_was_empty,
    output logic                                o_schedule_request,
    output logic                                o_push_refused,
    output logic [mrfow_pkg::LEN_W-1:0]         o_queue_length,
    output logic [mrfow_pkg::LEN_W-1:0]         o_overload_out
);

    localparam int AW = mrfow_pkg::ADDR_W;
    localparam int TW = mrfow_pkg::THR_W;
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(mrfow_pkg::DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(mrfow_pkg::DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    // Queue state
    logic [AW-1:0]                 r_rptr, n_rptr;
    logic [AW-1:0]                 r_wptr, n_wptr;
    logic [mrfow_pkg::LEN_W-1:0]   r_ovl, n_ovl;
    logic [TW-1:0]                 r_thr, n_thr;
    logic                          r_sched, n_sched;

    // Pending result of the word in flight
    logic                          r_got, n_got;
    logic                          r_empty, n_empty;
    logic                          r_sreq, n_sreq;
    logic                          r_refused, n_refused;
    logic [mrfow_pkg::LEN_W-1:0]   r_ovl_res, n_ovl_res;

    // Output register
    logic                          r_out_valid, n_out_valid;
    logic [mrfow_pkg::MSG_W-1:0]   r_o_msg, n_o_msg;
    logic                          r_o_got, n_o_got;
    logic                          r_o_empty, n_o_empty;
    logic                          r_o_sreq, n_o_sreq;
    logic                          r_o_refused, n_o_refused;
    logic [mrfow_pkg::LEN_W-1:0]   r_o_len, n_o_len;
    logic [mrfow_pkg::LEN_W-1:0]   r_o_ovl, n_o_ovl;

    logic [AW:0]                   w_held_ext;
    logic [AW-1:0]                 w_held;
    logic                          w_full;
    logic [TW-1:0]                 w_thr_dbl;
    logic [TW-1:0]                 w_base_thr;
    logic                          w_we;
    logic                          w_re;
    logic [mrfow_pkg::MSG_W-1:0]   w_rdata;

    assign w_held_ext = (r_wptr >= r_rptr) ? ({1'b0, r_wptr} - {1'b0, r_rptr})
                                           : ({1'b0, r_wptr} + DEPTH_EXT - {1'b0, r_rptr});
    assign w_held     = w_held_ext[AW-1:0];
    assign w_full     = (w_held == LAST_IDX);

    assign w_thr_dbl  = (r_thr[TW-2:0] == '0) ? TW'(1) : {r_thr[TW-2:0], 1'b0};
    assign w_base_thr = (i_base == '0) ? TW'(1) : {1'b0, i_base};

    assign o_sts.need_double = r_got && ({{(TW-AW){1'b0}}, w_held} > r_thr);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    mrfow_ram #(
        .WIDTH (mrfow_pkg::MSG_W),
        .DEPTH (mrfow_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (i_message_in),
        .i_re    (w_re),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_ovl       = r_ovl;
        n_thr       = r_thr;
        n_sched     = r_sched;
        n_got       = r_got;
        n_empty     = r_empty;
        n_sreq      = r_sreq;
        n_refused   = r_refused;
        n_ovl_res   = r_ovl_res;
        n_out_valid = r_out_valid;
        n_o_msg     = r_o_msg;
        n_o_got     = r_o_got;
        n_o_empty   = r_o_empty;
        n_o_sreq    = r_o_sreq;
        n_o_refused = r_o_refused;
        n_o_len     = r_o_len;
        n_o_ovl     = r_o_ovl;
        w_we        = 1'b0;
        w_re        = 1'b0;

        if (i_cmd.accept) begin
            n_got     = 1'b0;
            n_empty   = 1'b0;
            n_sreq    = 1'b0;
            n_refused = 1'b0;
            n_ovl_res = '0;
            case (i_kind)
                mrfow_pkg::KIND_PUSH: begin
                    if (w_full) begin
                        n_refused = 1'b1;
                    end else begin
                        w_we   = 1'b1;
                        n_wptr = ptr_inc(r_wptr);
                        if (!r_sched) begin
                            n_sched = 1'b1;
                            n_sreq  = 1'b1;
                        end
                    end
                end
                mrfow_pkg::KIND_POP: begin
                    if (r_rptr != r_wptr) begin
                        w_re   = 1'b1;
                        n_rptr = ptr_inc(r_rptr);
                        n_got  = 1'b1;
                    end else begin
                        n_empty = 1'b1;
                        n_thr   = w_base_thr;
                        n_sched = 1'b0;
                    end
                end
                mrfow_pkg::KIND_RDOVL: begin
                    n_ovl_res = r_ovl;
                    n_ovl     = '0;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.step) begin
            n_ovl = mrfow_pkg::sat_len(w_held);
            n_thr = w_thr_dbl;
        end

        if (i_cmd.load) begin
            n_out_valid = 1'b1;
            n_o_msg     = r_got ? w_rdata : '0;
            n_o_got     = r_got;
            n_o_empty   = r_empty;
            n_o_sreq    = r_sreq;
            n_o_refused = r_refused;
            n_o_len     = mrfow_pkg::sat_len(w_held);
            n_o_ovl     = r_ovl_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_ovl       <= '0;
            r_thr       <= {1'b0, mrfow_pkg::BASE_RESET};
            r_sched     <= 1'b1;
            r_got       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_ovl       <= n_ovl;
            r_thr       <= n_thr;
            r_sched     <= n_sched;
            r_got       <= n_got;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_empty     <= n_empty;
        r_sreq      <= n_sreq;
        r_refused   <= n_refused;
        r_ovl_res   <= n_ovl_res;
        r_o_msg     <= n_o_msg;
        r_o_got     <= n_o_got;
        r_o_empty   <= n_o_empty;
        r_o_sreq    <= n_o_sreq;
        r_o_refused <= n_o_refused;
        r_o_len     <= n_o_len;
        r_o_ovl     <= n_o_ovl;
    end

    assign o_out_valid        = r_out_valid;
    assign o_message_out      = r_o_msg;
    assign o_got_message      = r_o_got;
    assign o_was_empty        = r_o_empty;
    assign o_schedule_request = r_o_sreq;
    assign o_push_refused     = r_o_refused;
    assign o_queue_length     = r_o_len;
    assign o_overload_out     = r_o_ovl;

    a_refused_push_keeps_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && (i_kind == mrfow_pkg::KIND_PUSH) && w_full) |=> $stable(r_wptr))
        else $error("refused push moved the write pointer");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> $onehot0({r_got, r_empty, r_sreq, r_refused}))
        else $error("conflicting result flags");

    a_thr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_thr != '0)
        else $error("overload threshold reached zero");

    a_step_grows_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_thr > $past(r_thr)))
        else $error("threshold doubling did not raise the threshold");

endmodule

### sv/message_ring_fifo_overload_watch_core.sv
`timescale 1ns / 1ps
// Flow: an accepted word moves the controller from idle to run, where its result is loaded
//   into the output register; a pop that crosses the overload threshold first doubles the
//   threshold step by step until the length no longer exceeds it (at most 12 doublings here).
// The input stalls in run, so a new word is taken only after the last is loaded; a pop's
//   registered memory read lands in the run state, and doublings or an output stall prolong run.
// Reset (synchronous, active low): pointers and overload record cleared, threshold and base
//   register at 1024, scheduled flag set. Message memory is not cleared.

module message_ring_fifo_overload_watch_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mrfow_pkg::KIND_W-1:0]      i_kind,
    input  logic [mrfow_pkg::MSG_W-1:0]       i_message_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mrfow_pkg::MSG_W-1:0]       o_message_out,
    output logic                              o_got_message,
    output logic                              o_was_empty,
    output logic                              o_schedule_request,
    output logic                              o_push_refused,
    output logic [mrfow_pkg::LEN_W-1:0]       o_queue_length,
    output logic [mrfow_pkg::LEN_W-1:0]       o_overload_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam logic [2:0] ADDR_BASE_THR = 3'd0;

    logic [mrfow_pkg::BASE_W-1:0] r_base;
    logic                         w_cfg_we;
    mrfow_pkg::t_cmd              w_cmd;
    mrfow_pkg::t_sts              w_sts;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr == ADDR_BASE_THR);
    assign prdata   = (paddr == ADDR_BASE_THR) ? {{(32 - mrfow_pkg::BASE_W){1'b0}}, r_base}
                                               : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= mrfow_pkg::BASE_RESET;
        end else if (w_cfg_we) begin
            r_base <= pwdata[mrfow_pkg::BASE_W-1:0];
        end
    end

    mrfow_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mrfow_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_kind             (i_kind),
        .i_message_in       (i_message_in),
        .i_base             (r_base),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_message_out      (o_message_out),
        .o_got_message      (o_got_message),
        .o_was_empty        (o_was_empty),
        .o_schedule_request (o_schedule_request),
        .o_push_refused     (o_push_refused),
        .o_queue_length     (o_queue_length),
        .o_overload_out     (o_overload_out)
    );

endmodule
